// ===== design/id3p_pkg.sv =====
// shared types, phase codes and helpers for the tag frame parser
// no dependencies
`timescale 1ns / 1ps
package id3p_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       tag_start;
    logic       input_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  tag_version;
    logic [31:0] frame_id;
    logic [15:0] frame_flags;
    logic [27:0] payload_size;
    logic [7:0]  data_out;
    logic        data_valid;
    logic        frame_last;
    logic [2:0]  status;
  } out_item_t;

  // one step of the front part: up to two results
  typedef struct packed {
    logic      v0;
    out_item_t r0;
    logic      v1;
    out_item_t r1;
  } step_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HDR, PH_EXTSIZE, PH_EXTSKIP, PH_FHDR, PH_FSKIP, PH_PAYLOAD, PH_DONE
  } phase_t;

  localparam logic [1:0] KIND_FHDR = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_FIN  = 2'd2;

  localparam logic [2:0] ST_END    = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_BADHDR = 3'd2;
  localparam logic [2:0] ST_BADEXT = 3'd3;
  localparam logic [2:0] ST_BADSZ  = 3'd4;
  localparam logic [2:0] ST_COMP   = 3'd5;
  localparam logic [2:0] ST_SKIP   = 3'd6;
  localparam logic [2:0] ST_TRUNC  = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  function automatic logic [27:0] syncsafe28(input logic [31:0] w);
    syncsafe28 = {w[30:24], w[22:16], w[14:8], w[6:0]};
  endfunction

endpackage

// ===== design/id3p_front.sv =====
// front part: byte-level header and frame walk, one byte per cycle while go is high
// depends on id3p_pkg
`timescale 1ns / 1ps
module id3p_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  id3p_pkg::in_item_t in_d,
  output id3p_pkg::step_t   step
);

  id3p_pkg::phase_t ph_r, ph_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] sw_r, sw_nxt;
  logic [31:0] key_r, key_nxt;
  logic [15:0] ffw_r, ffw_nxt;
  logic [2:0]  ver_r, ver_nxt;
  logic        ext_r, ext_nxt;
  logic        tun_r, tun_nxt;
  logic [31:0] trem_r, trem_nxt;
  logic [31:0] frem_r, frem_nxt;
  logic [2:0]  srem_r, srem_nxt;
  logic        pff_r, pff_nxt;

  // tag header byte check by position
  function automatic logic hdr_bad(input logic [3:0] i, input logic [7:0] v);
    hdr_bad = (i == 4'd0 && v != 8'h49) || (i == 4'd1 && v != 8'h44) ||
              (i == 4'd2 && v != 8'h33) || (i == 4'd3 && v != 8'd3 && v != 8'd4) ||
              (i == 4'd4 && v != 8'd0);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= id3p_pkg::PH_IDLE; cnt_r <= '0; sw_r <= '0; key_r <= '0; ffw_r <= '0;
      ver_r <= '0; ext_r <= 1'b0; tun_r <= 1'b0; trem_r <= '0; frem_r <= '0;
      srem_r <= '0; pff_r <= 1'b0;
    end else if (go) begin
      ph_r <= ph_nxt; cnt_r <= cnt_nxt; sw_r <= sw_nxt; key_r <= key_nxt;
      ffw_r <= ffw_nxt; ver_r <= ver_nxt; ext_r <= ext_nxt; tun_r <= tun_nxt;
      trem_r <= trem_nxt; frem_r <= frem_nxt; srem_r <= srem_nxt; pff_r <= pff_nxt;
    end
  end

  always_comb begin
    id3p_pkg::phase_t ph;
    logic [3:0]  cnt;
    logic [31:0] sw, key, trem, frem, sws;
    logic [15:0] ffw;
    logic [2:0]  ver, srem, st, skp;
    logic        ext, tun, pff, fin, enter, keep, last, act;
    logic [7:0]  b;
    logic [32:0] tot;
    logic [31:0] sz;
    logic [27:0] ss;
    b = in_d.data_byte;
    ph = ph_r; cnt = cnt_r; sw = sw_r; key = key_r; ffw = ffw_r; ver = ver_r;
    ext = ext_r; tun = tun_r; trem = trem_r; frem = frem_r; srem = srem_r; pff = pff_r;
    fin = 1'b0; st = id3p_pkg::ST_END; enter = 1'b0; keep = 1'b1; last = 1'b0;
    tot = '0; sz = '0; ss = '0; skp = '0; act = 1'b0; sws = '0;
    step = '0;
    if (in_d.tag_start) begin
      ph = id3p_pkg::PH_HDR; cnt = '0; sw = '0; key = '0; ffw = '0; ver = '0;
      ext = 1'b0; tun = 1'b0; trem = '0; frem = '0; srem = '0; pff = 1'b0;
    end
    unique case (ph)
      id3p_pkg::PH_HDR: begin
        cnt = cnt + 4'd1;
        if (hdr_bad(cnt - 4'd1, b)) begin
          fin = 1'b1; st = id3p_pkg::ST_BADHDR;
        end else begin
          if (cnt == 4'd4) ver = b[2:0];
          if (cnt == 4'd6) begin ext = b[6]; tun = b[7]; end
          if (cnt >= 4'd7) sw = {sw[23:0], b};
          if (cnt == 4'd10) begin
            trem = {4'd0, id3p_pkg::syncsafe28(sw)};
            cnt = '0;
            if (ext) ph = id3p_pkg::PH_EXTSIZE;
            else enter = 1'b1;
          end
        end
      end
      id3p_pkg::PH_EXTSIZE: begin
        sw = {sw[23:0], b};
        cnt = cnt + 4'd1;
        if (cnt == 4'd4) begin
          ss = id3p_pkg::syncsafe28(sw);
          if (ver == 3'd3) begin
            tot = 33'd4 + {1'b0, sw}; sws = sw;
          end else begin
            tot = {5'd0, ss}; sws = {4'd0, ss} - 32'd4;
          end
          if ((ver != 3'd3 && ss < 28'd4) || tot > {1'b0, trem}) begin
            fin = 1'b1; st = id3p_pkg::ST_BADEXT;
          end else begin
            trem = trem - tot[31:0];
            if (sws == '0) enter = 1'b1;
            else begin frem = sws; ph = id3p_pkg::PH_EXTSKIP; end
          end
        end
      end
      id3p_pkg::PH_EXTSKIP: begin
        if (frem != '0) frem = frem - 32'd1;
        if (frem == '0) enter = 1'b1;
      end
      id3p_pkg::PH_FHDR: begin
        cnt = cnt + 4'd1;
        if (cnt == 4'd1 && b == 8'd0) begin
          fin = 1'b1; st = id3p_pkg::ST_PAD;
        end else begin
          if (cnt <= 4'd4) key = {key[23:0], b};
          else if (cnt <= 4'd8) sw = {sw[23:0], b};
          else ffw = {ffw[7:0], b};
          if (cnt == 4'd10) begin
            cnt = '0;
            sz = (ver == 3'd3) ? sw : {4'd0, id3p_pkg::syncsafe28(sw)};
            skp = (ffw[6] ? 3'd1 : 3'd0) + (ffw[0] ? 3'd4 : 3'd0);
            if (sz == '0 || sz > trem - 32'd10) begin
              fin = 1'b1; st = id3p_pkg::ST_BADSZ;
            end else if (ffw[3] || ffw[2]) begin
              fin = 1'b1; st = id3p_pkg::ST_COMP;
            end else if ({29'd0, skp} >= sz) begin
              fin = 1'b1; st = id3p_pkg::ST_SKIP;
            end else begin
              trem = trem - 32'd10 - sz;
              frem = sz - {29'd0, skp};
              srem = skp; pff = 1'b0;
              ph = (skp != '0) ? id3p_pkg::PH_FSKIP : id3p_pkg::PH_PAYLOAD;
              step.v0 = 1'b1;
              step.r0.result_kind = id3p_pkg::KIND_FHDR;
              step.r0.tag_version = ver;
              step.r0.frame_id = key;
              step.r0.frame_flags = ffw;
              step.r0.payload_size = frem[27:0];
            end
          end
        end
      end
      id3p_pkg::PH_FSKIP: begin
        if (srem != '0) srem = srem - 3'd1;
        if (srem == '0) ph = id3p_pkg::PH_PAYLOAD;
      end
      id3p_pkg::PH_PAYLOAD: begin
        act = tun | ffw[1];
        if (act && pff && b == 8'd0) begin keep = 1'b0; pff = 1'b0; end
        else pff = (b == 8'hFF);
        if (frem != '0) frem = frem - 32'd1;
        last = (frem == '0);
        step.v0 = 1'b1;
        step.r0.result_kind = id3p_pkg::KIND_DATA;
        step.r0.tag_version = ver;
        step.r0.frame_id = key;
        step.r0.data_out = keep ? b : 8'd0;
        step.r0.data_valid = keep;
        step.r0.frame_last = last;
        if (last) enter = 1'b1;
      end
      default: ;
    endcase
    if (enter) begin
      cnt = '0;
      if (trem == '0) begin fin = 1'b1; st = id3p_pkg::ST_END; end
      else if (trem < 32'd10) begin fin = 1'b1; st = id3p_pkg::ST_BADSZ; end
      else ph = id3p_pkg::PH_FHDR;
    end
    if (!fin && in_d.input_end && ph != id3p_pkg::PH_IDLE && ph != id3p_pkg::PH_DONE) begin
      fin = 1'b1; st = id3p_pkg::ST_TRUNC;
    end
    if (fin) begin
      ph = id3p_pkg::PH_DONE;
      if (step.v0) begin
        step.v1 = 1'b1;
        step.r1.result_kind = id3p_pkg::KIND_FIN;
        step.r1.tag_version = ver;
        step.r1.status = st;
      end else begin
        step.v0 = 1'b1;
        step.r0.result_kind = id3p_pkg::KIND_FIN;
        step.r0.tag_version = (st == id3p_pkg::ST_BADHDR) ? 3'd0 : ver;
        step.r0.status = st;
      end
    end
    ph_nxt = ph; cnt_nxt = cnt; sw_nxt = sw; key_nxt = key; ffw_nxt = ffw; ver_nxt = ver;
    ext_nxt = ext; tun_nxt = tun; trem_nxt = trem; frem_nxt = frem; srem_nxt = srem;
    pff_nxt = pff;
  end

endmodule

// ===== design/id3p_back.sv =====
// back part: result queue, drains up to two results per step one per pop
// depends on id3p_pkg
`timescale 1ns / 1ps
module id3p_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr,
  input  id3p_pkg::step_t     step,
  output logic                full,
  output logic                empty,
  input  logic                pop,
  output id3p_pkg::out_item_t head
);

  id3p_pkg::out_item_t mem_r [id3p_pkg::QDEPTH];
  logic [id3p_pkg::QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [id3p_pkg::QAW:0]   cnt_r, cnt_nxt;
  logic do_pop;
  logic [id3p_pkg::QAW:0] nin;

  assign empty  = (cnt_r == '0);
  assign full   = (cnt_r > 3'(id3p_pkg::QDEPTH - 2));
  assign head   = mem_r[rp_r];
  assign do_pop = pop && !empty;

  always_comb begin
    nin = '0;
    if (wr) nin = {2'd0, step.v0} + {2'd0, step.v1};
    wp_nxt  = wp_r + nin[id3p_pkg::QAW-1:0];
    rp_nxt  = rp_r + {1'b0, do_pop};
    cnt_nxt = cnt_r + nin - {2'd0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr && step.v0) mem_r[wp_r] <= step.r0;
    if (wr && step.v1) mem_r[wp_r + 2'd1] <= step.r1;
  end

endmodule

// ===== design/id3v2_tag_frame_parser_top.sv =====
// tag frame parser top: one byte accepted per cycle while in_full is low
// results of an accepted byte are queued, and empty falls, in the next cycle
// a byte yields up to two results, drained one per pop from a 4-entry queue
// full rises when fewer than two entries are free
// synchronous active-low reset clears parse state and empties the queue
`timescale 1ns / 1ps
module id3v2_tag_frame_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  id3p_pkg::in_item_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output id3p_pkg::out_item_t out_data
);

  id3p_pkg::step_t step;
  logic go;

  assign go = in_push && !in_full;

  id3p_front u_front (.clk(clk), .rst_n(rst_n), .go(go), .in_d(in_data), .step(step));

  id3p_back u_back (
    .clk(clk), .rst_n(rst_n), .wr(go), .step(step), .full(in_full),
    .empty(out_empty), .pop(out_pop), .head(out_data)
  );

endmodule

// ===== tb/sv/id3v2_tag_frame_parser_top_tb.sv =====
// testbench for the tag frame parser top: directed tags, then random tag streams
// depends on id3p_pkg and id3v2_tag_frame_parser_top; results checked against a local predictor
`timescale 1ns / 1ps
module id3v2_tag_frame_parser_top_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  id3p_pkg::in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  id3p_pkg::out_item_t out_data;

  id3v2_tag_frame_parser_top uut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  id3p_pkg::phase_t pr_phase;
  int unsigned pr_cnt;
  logic [31:0] pr_shift, pr_key, pr_tagrem, pr_frrem;
  logic [15:0] pr_fflags;
  logic [2:0] pr_ver, pr_skip;
  logic [7:0] pr_tflags;
  logic pr_unsync, pr_prevff;

  id3p_pkg::out_item_t expected_results[$];
  int fail_count = 0;
  bit calm = 1'b0;
  byte unsigned tag_bytes[$];

  function automatic logic [31:0] decode_ss(input logic [31:0] w);
    return {4'd0, w[30:24], w[22:16], w[14:8], w[6:0]};
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [2:0] v, input logic [31:0] id,
                             input logic [15:0] fl, input logic [27:0] ps, input logic [7:0] d,
                             input logic dv, input logic lst, input logic [2:0] st);
    id3p_pkg::out_item_t r;
    r.result_kind = k; r.tag_version = v; r.frame_id = id; r.frame_flags = fl;
    r.payload_size = ps; r.data_out = d; r.data_valid = dv; r.frame_last = lst;
    r.status = st;
    expected_results.push_back(r);
  endtask

  task automatic finish_parse(input logic [2:0] st);
    pr_phase = id3p_pkg::PH_DONE;
    push_result(id3p_pkg::KIND_FIN, st == id3p_pkg::ST_BADHDR ? 3'd0 : pr_ver, '0, '0, '0,
                '0, 1'b0, 1'b0, st);
  endtask

  task automatic enter_frames();
    pr_cnt = 0;
    if (pr_tagrem == 0) finish_parse(id3p_pkg::ST_END);
    else if (pr_tagrem < 10) finish_parse(id3p_pkg::ST_BADSZ);
    else pr_phase = id3p_pkg::PH_FHDR;
  endtask

  task automatic predict_byte(input id3p_pkg::in_item_t it);
    logic [7:0] b;
    int unsigned i;
    logic [31:0] sz, sk;
    logic [32:0] total;
    logic keep, lst;
    b = it.data_byte;
    if (it.tag_start) begin
      pr_phase = id3p_pkg::PH_HDR; pr_cnt = 0; pr_shift = 0; pr_key = 0; pr_fflags = 0;
      pr_ver = 0; pr_tflags = 0; pr_unsync = 0; pr_tagrem = 0; pr_frrem = 0; pr_skip = 0;
      pr_prevff = 0;
    end
    i = pr_cnt;
    case (pr_phase)
      id3p_pkg::PH_HDR: begin
        pr_cnt = (pr_cnt + 1) % 16;
        if ((i == 0 && b != 8'h49) || (i == 1 && b != 8'h44) || (i == 2 && b != 8'h33) ||
            (i == 3 && b != 3 && b != 4) || (i == 4 && b != 0)) begin
          finish_parse(id3p_pkg::ST_BADHDR);
        end else begin
          if (i == 3) pr_ver = b[2:0];
          if (i == 5) begin
            pr_tflags = b; pr_unsync = b[7];
          end
          if (i >= 6) pr_shift = {pr_shift[23:0], b};
          if (i == 9) begin
            pr_tagrem = decode_ss(pr_shift);
            pr_cnt = 0;
            if (pr_tflags[6]) pr_phase = id3p_pkg::PH_EXTSIZE;
            else enter_frames();
          end
        end
      end
      id3p_pkg::PH_EXTSIZE: begin
        pr_shift = {pr_shift[23:0], b};
        pr_cnt = (pr_cnt + 1) % 16;
        if (pr_cnt >= 4) begin
          if (pr_ver == 3) begin
            total = 33'd4 + {1'b0, pr_shift}; sk = pr_shift;
          end else begin
            total = {1'b0, decode_ss(pr_shift)}; sk = total[31:0] - 32'd4;
          end
          if ((pr_ver != 3 && total < 4) || total > {1'b0, pr_tagrem})
            finish_parse(id3p_pkg::ST_BADEXT);
          else begin
            pr_tagrem = pr_tagrem - total[31:0];
            if (sk == 0) enter_frames();
            else begin
              pr_frrem = sk; pr_phase = id3p_pkg::PH_EXTSKIP;
            end
          end
        end
      end
      id3p_pkg::PH_EXTSKIP: begin
        if (pr_frrem > 0) pr_frrem--;
        if (pr_frrem == 0) enter_frames();
      end
      id3p_pkg::PH_FHDR: begin
        pr_cnt = (pr_cnt + 1) % 16;
        if (i == 0 && b == 0) finish_parse(id3p_pkg::ST_PAD);
        else begin
          if (i < 4) pr_key = {pr_key[23:0], b};
          else if (i < 8) pr_shift = {pr_shift[23:0], b};
          else pr_fflags = {pr_fflags[7:0], b};
          if (i == 9) begin
            pr_cnt = 0;
            sz = (pr_ver == 3) ? pr_shift : decode_ss(pr_shift);
            sk = (pr_fflags[6] ? 32'd1 : 32'd0) + (pr_fflags[0] ? 32'd4 : 32'd0);
            if (sz == 0 || sz > pr_tagrem - 32'd10) finish_parse(id3p_pkg::ST_BADSZ);
            else if (pr_fflags[3] || pr_fflags[2]) finish_parse(id3p_pkg::ST_COMP);
            else if (sk >= sz) finish_parse(id3p_pkg::ST_SKIP);
            else begin
              pr_tagrem = pr_tagrem - 32'd10 - sz;
              pr_frrem = sz - sk;
              pr_skip = sk[2:0];
              pr_prevff = 0;
              pr_phase = (sk != 0) ? id3p_pkg::PH_FSKIP : id3p_pkg::PH_PAYLOAD;
              push_result(id3p_pkg::KIND_FHDR, pr_ver, pr_key, pr_fflags,
                          sz[27:0] - sk[27:0], '0, 1'b0, 1'b0, '0);
            end
          end
        end
      end
      id3p_pkg::PH_FSKIP: begin
        if (pr_skip > 0) pr_skip--;
        if (pr_skip == 0) pr_phase = id3p_pkg::PH_PAYLOAD;
      end
      id3p_pkg::PH_PAYLOAD: begin
        keep = 1'b1;
        if ((pr_unsync || pr_fflags[1]) && pr_prevff && b == 0) begin
          keep = 1'b0; pr_prevff = 0;
        end else pr_prevff = (b == 8'hff);
        if (pr_frrem > 0) pr_frrem--;
        lst = (pr_frrem == 0);
        push_result(id3p_pkg::KIND_DATA, pr_ver, pr_key, '0, '0, keep ? b : 8'h00, keep, lst,
                    '0);
        if (lst) enter_frames();
      end
      default: ;
    endcase
    if (it.input_end && pr_phase != id3p_pkg::PH_IDLE && pr_phase != id3p_pkg::PH_DONE)
      finish_parse(id3p_pkg::ST_TRUNC);
  endtask

  // one transfer on the input side
  task automatic send_byte(input logic [7:0] b, input logic st, input logic en);
    id3p_pkg::in_item_t it;
    while (!calm && $urandom_range(99) < 10) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    it.data_byte = b; it.tag_start = st; it.input_end = en;
    in_data <= it;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_byte(it);
    @(negedge clk);
  endtask

  // sends the queued stream, first byte as tag start, last as end when mark_end is set
  task automatic send_stream(input bit mark_end);
    for (int k = 0; k < tag_bytes.size(); k++)
      send_byte(tag_bytes[k], k == 0, mark_end && k == tag_bytes.size() - 1);
    tag_bytes.delete();
    in_push <= 1'b0;
    @(negedge clk);
  endtask

  always @(negedge clk) out_pop <= calm ? 1'b1 : ($urandom_range(99) >= 10);

  always @(posedge clk) begin
    id3p_pkg::out_item_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, out_data.result_kind);
          fail_count++;
        end
        if (out_data.tag_version !== e.tag_version) begin
          $error("tag_version exp %0d got %0d", e.tag_version, out_data.tag_version);
          fail_count++;
        end
        if (out_data.frame_id !== e.frame_id) begin
          $error("frame_id exp %h got %h", e.frame_id, out_data.frame_id);
          fail_count++;
        end
        if (out_data.frame_flags !== e.frame_flags) begin
          $error("frame_flags exp %h got %h", e.frame_flags, out_data.frame_flags);
          fail_count++;
        end
        if (out_data.payload_size !== e.payload_size) begin
          $error("payload_size exp %0d got %0d", e.payload_size, out_data.payload_size);
          fail_count++;
        end
        if (out_data.data_out !== e.data_out) begin
          $error("data_out exp %h got %h", e.data_out, out_data.data_out);
          fail_count++;
        end
        if (out_data.data_valid !== e.data_valid) begin
          $error("data_valid exp %0d got %0d", e.data_valid, out_data.data_valid);
          fail_count++;
        end
        if (out_data.frame_last !== e.frame_last) begin
          $error("frame_last exp %0d got %0d", e.frame_last, out_data.frame_last);
          fail_count++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  task automatic add_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) tag_bytes.push_back(w[8*k +: 8]);
  endtask

  function automatic logic [31:0] encode_ss(input int unsigned v);
    return {1'b0, v[27:21], 1'b0, v[20:14], 1'b0, v[13:7], 1'b0, v[6:0]};
  endfunction

  task automatic add_tag_header(input logic [7:0] ver, input logic [7:0] fl,
                                input int unsigned sz);
    tag_bytes.push_back(8'h49); tag_bytes.push_back(8'h44); tag_bytes.push_back(8'h33);
    tag_bytes.push_back(ver); tag_bytes.push_back(8'h00); tag_bytes.push_back(fl);
    add_word(encode_ss(sz));
  endtask

  task automatic add_frame(input logic [7:0] ver, input logic [31:0] key,
                           input int unsigned sz, input logic [15:0] fl, input bit ffrich);
    add_word(key);
    add_word(ver == 8'd3 ? sz : encode_ss(sz));
    tag_bytes.push_back(fl[15:8]); tag_bytes.push_back(fl[7:0]);
    for (int k = 0; k < sz; k++)
      tag_bytes.push_back(ffrich ? ($urandom_range(1) ? 8'hff : 8'h00) :
                                   8'($urandom_range(255)));
  endtask

  task automatic test_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_directed();
    // bad magic, bad version, bad revision
    tag_bytes = '{8'h48, 8'h44};
    send_stream(0);
    tag_bytes = '{8'h49, 8'h44, 8'h33, 8'h05};
    send_stream(0);
    tag_bytes = '{8'h49, 8'h44, 8'h33, 8'h04, 8'hff};
    send_stream(0);
    // empty tag finishes with ST_END status
    add_tag_header(8'd3, 8'h00, 0);
    send_stream(0);
    // extremes: all-ones bytes and all-zero bytes, bytes ignored after finish
    tag_bytes = '{8'hff, 8'h00, 8'hff};
    send_stream(1);
    // unsync tag, one frame with grouping and length, then padding
    add_tag_header(8'd4, 8'h80, 40);
    add_frame(8'd4, 32'h54495432, 12, 16'h0041, 1);
    tag_bytes.push_back(8'h00);
    send_stream(0);
    // v2.3 extended header, compressed frame
    add_tag_header(8'd3, 8'h40, 40);
    add_word(32'd2); tag_bytes.push_back(8'h00); tag_bytes.push_back(8'h00);
    add_frame(8'd3, 32'h434f4d4d, 3, 16'h0008, 0);
    send_stream(0);
    // v2.4 bad extended size, v2.4 skip too long, v2.3 bad frame size, v2.4 truncation
    add_tag_header(8'd4, 8'h40, 30); add_word(32'd2);
    send_stream(0);
    add_tag_header(8'd4, 8'h00, 30); add_frame(8'd4, 32'h41424344, 1, 16'h0040, 0);
    send_stream(0);
    add_tag_header(8'd3, 8'h00, 15); add_frame(8'd3, 32'h41424344, 0, 16'h0000, 0);
    send_stream(0);
    add_tag_header(8'd4, 8'h00, 15);
    send_stream(1);
  endtask

  task automatic test_random_tags();
    logic [7:0] ver;
    int unsigned nfr, tot, sz;
    logic [15:0] fl;
    int unsigned sent;
    bit broken;
    sent = 0;
    while (sent < 1750) begin
      if (sent > 700 && sent < 1000) calm = 1'b1;
      else calm = 1'b0;
      ver = 8'($urandom_range(3, 4));
      nfr = $urandom_range(1, 4);
      tot = 0;
      for (int k = 0; k < nfr; k++) tot += 10 + $urandom_range(1, 12);
      tot += $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0;
      add_tag_header(ver, {1'($urandom_range(1)), 7'd0}, tot);
      for (int k = 0; k < nfr && tag_bytes.size() < tot; k++) begin
        sz = $urandom_range(1, 12);
        fl = $urandom_range(7) == 0 ? 16'($urandom()) : {8'h00, 1'b0, $urandom_range(1) == 1,
             4'b0000, $urandom_range(1) == 1, $urandom_range(1) == 1};
        add_frame(ver, {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)), 8'h30 + 8'(k),
                        8'($urandom_range(48, 57))}, sz, fl, 1'($urandom_range(1)));
      end
      broken = ($urandom_range(9) == 0);
      if (broken) tag_bytes[$urandom_range(tag_bytes.size() - 1)] = 8'($urandom_range(255));
      while (tag_bytes.size() < tot + 10) tag_bytes.push_back(8'h00);
      if ($urandom_range(9) == 0) tag_bytes = tag_bytes[0:$urandom_range(tag_bytes.size()-1)];
      sent += tag_bytes.size();
      send_stream(1'($urandom_range(1)));
    end
    calm = 1'b0;
  endtask

  initial begin
    test_reset();
    test_directed();
    test_random_tags();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("** id3v2_tag_frame_parser_top: PASSED **");
    else $display("** id3v2_tag_frame_parser_top: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** id3v2_tag_frame_parser_top: FAILED **");
    $finish;
  end
endmodule
